@@ sv/owfl_pkg.sv @@
// Shared constants and codes for the overwrite ring FIFO with low-water flag.
package owfl_pkg;

    localparam int BYTE_W     = 8;
    localparam int REQ_W      = 7;
    localparam int LW_W       = 11;
    localparam int CFG_IDX_W  = 1;

    // Item kinds carried on the input tuser
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_ENABLED = 1'b1;

    localparam logic [LW_W-1:0] LOW_WATER_RST = 11'd512;

endpackage

@@ sv/owfl_ram.sv @@
// Byte store of the ring: one write port, one read port with registered data.
module owfl_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [owfl_pkg::BYTE_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [owfl_pkg::BYTE_W-1:0]   o_rdata
);

    logic [owfl_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [owfl_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/overwrite_ring_fifo_low_water.sv @@
// Overwrite-oldest byte ring FIFO with a low-water refill request.
//
// Input items arrive on the s_axis channel. tuser selects the action:
// push stores the byte in tdata[7:0]; read asks for tdata[14:8] bytes.
// Each push gives one result; a read gives min(request, MAX_READ, fill)
// results oldest first with tlast on the final one, or one no-data result
// when the request is zero or the ring is empty. A push into a full ring
// drops the oldest byte and flags it in tuser. Every result carries the
// fill level after it and the refill request (fill below the low-water
// threshold, clamped to DEPTH, while the pool is enabled).
// A push result is registered and appears the cycle after acceptance; a read
// byte passes through store read, output load and handoff, in that order,
// paced by the single registered read port of the byte store.
// s_axis_tready is high only while the sequencer is idle, so one item is
// in work at a time. A stalled receiver holds the result in the output
// register and the sequencer waits. Reset empties the ring and loads the
// registers with low_water 512, pool disabled. The cfg channel is always
// ready; write it only while the block is idle.
module overwrite_ring_fifo_low_water #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64,
    localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int OD_W    = ((owfl_pkg::BYTE_W + CW + 1 + 7) / 8) * 8,
    localparam int ID_W    = ((owfl_pkg::BYTE_W + owfl_pkg::REQ_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] push_byte, [14:8] read_count, rest zero
    input  logic [ID_W-1:0]                 s_axis_tdata,
    // [0] action
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_byte, [CW+7:8] fill_level, [CW+8] refill_request, rest zero
    output logic [OD_W-1:0]                 m_axis_tdata,
    // [0] has_data, [1] overwrote
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [owfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owfl_pkg::LW_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } t_state;

    t_state r_state;

    logic [PW-1:0]                  r_rptr;
    logic [PW-1:0]                  r_wptr;
    logic [CW-1:0]                  r_held;
    logic [owfl_pkg::REQ_W-1:0]     r_left;
    logic [owfl_pkg::LW_W-1:0]      r_low_water;
    logic                           r_pool_en;

    logic [owfl_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_out_has;
    logic                           r_out_last;
    logic                           r_out_ovw;
    logic [CW-1:0]                  r_out_fill;
    logic                           r_out_refill;

    logic                           w_in_acc;
    logic                           w_push;
    logic                           w_full;
    logic [owfl_pkg::BYTE_W-1:0]    w_rdata;
    logic [CW-1:0]                  w_thr;
    logic [owfl_pkg::REQ_W-1:0]     w_req;
    logic [owfl_pkg::REQ_W-1:0]     w_req_sat;
    logic [owfl_pkg::REQ_W-1:0]     w_n;
    logic [PW-1:0]                  n_rptr;
    logic [PW-1:0]                  n_wptr;
    logic [CW-1:0]                  n_held_inc;
    logic [CW-1:0]                  n_held_dec;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_push        = w_in_acc && (s_axis_tuser == owfl_pkg::ACT_PUSH);
    assign w_full        = (r_held == CW'(DEPTH));
    assign w_req         = s_axis_tdata[owfl_pkg::BYTE_W +: owfl_pkg::REQ_W];

    assign n_rptr     = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    assign n_wptr     = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_held_inc = r_held + 1'b1;
    assign n_held_dec = r_held - 1'b1;

    // Clamp the threshold at the ring depth
    always_comb begin
        if (32'(r_low_water) > DEPTH) begin
            w_thr = CW'(DEPTH);
        end else begin
            w_thr = CW'(r_low_water);
        end
    end

    always_comb begin
        if (32'(w_req) > MAX_READ) begin
            w_req_sat = owfl_pkg::REQ_W'(MAX_READ);
        end else begin
            w_req_sat = w_req;
        end
        if (32'(r_held) < 32'(w_req_sat)) begin
            w_n = owfl_pkg::REQ_W'(r_held);
        end else begin
            w_n = w_req_sat;
        end
    end

    owfl_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wptr),
        .i_wdata (s_axis_tdata[owfl_pkg::BYTE_W-1:0]),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_water <= owfl_pkg::LOW_WATER_RST;
            r_pool_en   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                owfl_pkg::REG_LOW_WATER:    r_low_water <= i_cfg_data;
                owfl_pkg::REG_POOL_ENABLED: r_pool_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rptr  <= '0;
            r_wptr  <= '0;
            r_held  <= '0;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_push) begin
                        r_wptr       <= n_wptr;
                        r_out_byte   <= '0;
                        r_out_has    <= 1'b0;
                        r_out_last   <= 1'b1;
                        if (w_full) begin
                            // drop the oldest byte, fill stays at depth
                            r_rptr       <= n_rptr;
                            r_out_ovw    <= 1'b1;
                            r_out_fill   <= r_held;
                            r_out_refill <= (r_held < w_thr) && r_pool_en;
                        end else begin
                            r_held       <= n_held_inc;
                            r_out_ovw    <= 1'b0;
                            r_out_fill   <= n_held_inc;
                            r_out_refill <= (n_held_inc < w_thr) && r_pool_en;
                        end
                        r_state <= ST_SEND;
                    end else if (w_in_acc) begin
                        if (w_n == '0) begin
                            r_out_byte   <= '0;
                            r_out_has    <= 1'b0;
                            r_out_last   <= 1'b1;
                            r_out_ovw    <= 1'b0;
                            r_out_fill   <= r_held;
                            r_out_refill <= (r_held < w_thr) && r_pool_en;
                            r_state      <= ST_SEND;
                        end else begin
                            r_left  <= w_n;
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    // store read at the head pointer lands this cycle
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_out_byte   <= w_rdata;
                    r_out_has    <= 1'b1;
                    r_out_last   <= (r_left == owfl_pkg::REQ_W'(1));
                    r_out_ovw    <= 1'b0;
                    r_out_fill   <= n_held_dec;
                    r_out_refill <= (n_held_dec < w_thr) && r_pool_en;
                    r_rptr       <= n_rptr;
                    r_held       <= n_held_dec;
                    r_left       <= r_left - 1'b1;
                    r_state      <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_axis_tready) begin
                        r_state <= r_out_last ? ST_IDLE : ST_FETCH;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == ST_SEND);
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_ovw, r_out_has};
    assign m_axis_tdata  = OD_W'({r_out_refill, r_out_fill, r_out_byte});

endmodule
